[rtl/rms_pkg.sv]
package rms_pkg;

  localparam int MEM_WORDS  = 1024;
  localparam int PROG_WORDS = 4096;
  localparam int NUM_REGS   = 8;

  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int PLEN_W    = 13;
  localparam int WORD_W    = 64;

  localparam int IN_W  = 72;
  localparam int OUT_W = 264;

  localparam logic [WORD_W-1:0] COST_IO  = 64'd100;
  localparam logic [WORD_W-1:0] COST_MEM = 64'd50;
  localparam logic [WORD_W-1:0] COST_ALU = 64'd5;
  localparam logic [WORD_W-1:0] COST_ONE = 64'd1;

  typedef enum logic [4:0] {
    OP_READ   = 5'd0,
    OP_WRITE  = 5'd1,
    OP_LOAD   = 5'd2,
    OP_STORE  = 5'd3,
    OP_RLOAD  = 5'd4,
    OP_RSTORE = 5'd5,
    OP_ADD    = 5'd6,
    OP_SUB    = 5'd7,
    OP_SWP    = 5'd8,
    OP_RST    = 5'd9,
    OP_INC    = 5'd10,
    OP_DEC    = 5'd11,
    OP_SHL    = 5'd12,
    OP_SHR    = 5'd13,
    OP_JUMP   = 5'd14,
    OP_JPOS   = 5'd15,
    OP_JZERO  = 5'd16,
    OP_CALL   = 5'd17,
    OP_RTRN   = 5'd18,
    OP_HALT   = 5'd19
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_HALT     = 2'd1,
    ST_PC_OOB   = 2'd2,
    ST_ADDR_OOB = 2'd3
  } status_t;

  typedef logic [NUM_REGS-1:0][WORD_W-1:0] reg_file_t;

  typedef struct packed {
    status_t              status;
    logic                 wr_valid;
    logic [WORD_W-1:0]    wr_value;
    logic [WORD_W-1:0]    pc;
    logic [WORD_W-1:0]    cycle;
    logic [WORD_W-1:0]    io;
    logic                 reg0_we;
    logic [WORD_W-1:0]    reg0_wd;
    logic                 regi_we;
    logic [REG_IDX_W-1:0] regi_idx;
    logic [WORD_W-1:0]    regi_wd;
    logic                 mem_we;
    logic [MEM_AW-1:0]    mem_addr;
  } exec_res_t;

endpackage

[rtl/rms_exec.sv]
module rms_exec
  import rms_pkg::*;
(
  input  logic [4:0]        mode,
  input  logic [WORD_W-1:0] operand,
  input  reg_file_t         regs,
  input  logic [WORD_W-1:0] mem_rdata,
  input  logic [WORD_W-1:0] pc,
  input  logic [WORD_W-1:0] cycle,
  input  logic [WORD_W-1:0] io,
  input  logic [PLEN_W-1:0] prog_len,
  output exec_res_t         res
);

  logic [REG_IDX_W-1:0] ri;
  logic [WORD_W-1:0]    rsel;
  logic [WORD_W-1:0]    acc;
  logic [WORD_W-1:0]    pc_inc;
  logic [WORD_W-1:0]    bound;
  logic [WORD_W-1:0]    addr;
  logic                 is_mem;
  logic                 addr_ok;
  op_t                  op;

  assign op      = op_t'(mode);
  assign ri      = operand[REG_IDX_W-1:0];
  assign rsel    = regs[ri];
  assign acc     = regs[0];
  assign pc_inc  = pc + 64'd1;
  assign bound   = (64'(prog_len) < 64'(PROG_WORDS)) ? 64'(prog_len) : 64'(PROG_WORDS);
  assign is_mem  = (op == OP_LOAD) || (op == OP_STORE) || (op == OP_RLOAD) ||
                   (op == OP_RSTORE);
  assign addr    = ((op == OP_LOAD) || (op == OP_STORE)) ? operand : rsel;
  assign addr_ok = addr < 64'(MEM_WORDS);

  always_comb begin
    res          = '0;
    res.status   = ST_OK;
    res.pc       = pc;
    res.cycle    = cycle;
    res.io       = io;
    res.regi_idx = ri;
    res.mem_addr = addr[MEM_AW-1:0];
    if (pc >= bound) begin
      res.status = ST_PC_OOB;
    end else if (op == OP_HALT) begin
      res.status = ST_HALT;
    end else if (is_mem && !addr_ok) begin
      res.status = ST_ADDR_OOB;
    end else begin
      unique case (op)
        OP_READ: begin
          res.reg0_we = 1'b1;
          res.io      = io + COST_IO;
          res.pc      = pc_inc;
        end
        OP_WRITE: begin
          res.wr_valid = 1'b1;
          res.wr_value = acc;
          res.io       = io + COST_IO;
          res.pc       = pc_inc;
        end
        OP_LOAD, OP_RLOAD: begin
          res.reg0_we = 1'b1;
          res.reg0_wd = mem_rdata;
          res.cycle   = cycle + COST_MEM;
          res.pc      = pc_inc;
        end
        OP_STORE, OP_RSTORE: begin
          res.mem_we = 1'b1;
          res.cycle  = cycle + COST_MEM;
          res.pc     = pc_inc;
        end
        OP_ADD: begin
          res.reg0_we = 1'b1;
          res.reg0_wd = acc + rsel;
          res.cycle   = cycle + COST_ALU;
          res.pc      = pc_inc;
        end
        OP_SUB: begin
          res.reg0_we = 1'b1;
          res.reg0_wd = (acc >= rsel) ? acc - rsel : '0;
          res.cycle   = cycle + COST_ALU;
          res.pc      = pc_inc;
        end
        OP_SWP: begin
          res.reg0_we = 1'b1;
          res.reg0_wd = rsel;
          res.regi_we = 1'b1;
          res.regi_wd = acc;
          res.cycle   = cycle + COST_ALU;
          res.pc      = pc_inc;
        end
        OP_RST, OP_INC, OP_DEC, OP_SHL, OP_SHR: begin
          res.regi_we = 1'b1;
          res.cycle   = cycle + COST_ONE;
          res.pc      = pc_inc;
          case (op)
            OP_INC:  res.regi_wd = rsel + 64'd1;
            OP_DEC:  res.regi_wd = (rsel != '0) ? rsel - 64'd1 : '0;
            OP_SHL:  res.regi_wd = {rsel[WORD_W-2:0], 1'b0};
            OP_SHR:  res.regi_wd = {1'b0, rsel[WORD_W-1:1]};
            default: res.regi_wd = '0;
          endcase
        end
        OP_JUMP: begin
          res.pc    = operand;
          res.cycle = cycle + COST_ONE;
        end
        OP_JPOS: begin
          res.pc    = (acc != '0) ? operand : pc_inc;
          res.cycle = cycle + COST_ONE;
        end
        OP_JZERO: begin
          res.pc    = (acc == '0) ? operand : pc_inc;
          res.cycle = cycle + COST_ONE;
        end
        OP_CALL: begin
          res.reg0_we = 1'b1;
          res.reg0_wd = pc_inc;
          res.pc      = operand;
          res.cycle   = cycle + COST_ONE;
        end
        OP_RTRN: begin
          res.pc    = acc;
          res.cycle = cycle + COST_ONE;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/register_machine_step_core.sv]
// Channel  | Direction | Beat contents (lowest bits first)
// in_      | slave     | mode[4:0], operand[68:5], zero pad to 72
// out_     | master    | next_pc, status, write_valid, write_value, cycle_total, io_total
// cfg_     | write     | program_length[12:0]
//
// Each instruction has its data memory read registered, then executes and writes back
// registers, memory and the result register; a new instruction can enter meanwhile.
// The result register decouples the output; a beat is taken while a stage is free.
// After reset a clearing pass zeroes every data memory word; in_tready is low meanwhile.
// Reset is synchronous, active low; configuration writes are taken at any time.
module register_machine_step_core
  import rms_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,   // mode[4:0], operand[68:5]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,  // next_pc[63:0], status[65:64], write_valid[66],
                                        // write_value[130:67], cycle_total[194:131],
                                        // io_total[258:195]
  input  logic              cfg_wr_en,
  input  logic [PLEN_W-1:0] cfg_wr_data
);

  logic [WORD_W-1:0] mem [MEM_WORDS];
  logic [WORD_W-1:0] mem_rdata_r;

  reg_file_t         regs_r;
  reg_file_t         regs_nxt;
  logic [WORD_W-1:0] pc_r;
  logic [WORD_W-1:0] cycle_r;
  logic [WORD_W-1:0] io_r;
  logic [PLEN_W-1:0] prog_len_r;

  logic              clr_busy_r;
  logic [MEM_AW-1:0] clr_addr_r;

  logic              a_valid_r;
  logic [4:0]        a_mode_r;
  logic [WORD_W-1:0] a_opd_r;
  logic              b_valid_r;
  logic [4:0]        b_mode_r;
  logic [WORD_W-1:0] b_opd_r;

  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;
  logic [OUT_W-1:0]  out_data_nxt;

  logic              in_fire;
  logic              a_to_b;
  logic              b_done;
  logic [WORD_W-1:0] a_addr;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  exec_res_t         ex;

  assign in_tready  = !clr_busy_r && (!a_valid_r || !b_valid_r);
  assign in_fire    = in_tvalid && in_tready;
  assign a_to_b     = a_valid_r && !b_valid_r;
  assign b_done     = b_valid_r && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign a_addr = ((op_t'(a_mode_r) == OP_LOAD) || (op_t'(a_mode_r) == OP_STORE)) ?
                  a_opd_r : regs_r[a_opd_r[REG_IDX_W-1:0]];

  rms_exec u_exec (
    .mode      (b_mode_r),
    .operand   (b_opd_r),
    .regs      (regs_r),
    .mem_rdata (mem_rdata_r),
    .pc        (pc_r),
    .cycle     (cycle_r),
    .io        (io_r),
    .prog_len  (prog_len_r),
    .res       (ex)
  );

  assign mem_we    = clr_busy_r || (b_done && ex.mem_we);
  assign mem_waddr = clr_busy_r ? clr_addr_r : ex.mem_addr;
  assign mem_wdata = clr_busy_r ? '0 : regs_r[0];

  assign out_data_nxt = {5'b0, ex.io, ex.cycle, ex.wr_value, ex.wr_valid, ex.status, ex.pc};

  always_comb begin
    regs_nxt = regs_r;
    if (b_done && ex.regi_we) begin
      regs_nxt[ex.regi_idx] = ex.regi_wd;
    end
    if (b_done && ex.reg0_we) begin
      regs_nxt[0] = ex.reg0_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (a_to_b) begin
      mem_rdata_r <= mem[a_addr[MEM_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_mode_r <= in_tdata[4:0];
      a_opd_r  <= in_tdata[68:5];
    end
    if (a_to_b) begin
      b_mode_r <= a_mode_r;
      b_opd_r  <= a_opd_r;
    end
    if (b_done) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      regs_r      <= '0;
      pc_r        <= '0;
      cycle_r     <= '0;
      io_r        <= '0;
      prog_len_r  <= '0;
    end else begin
      a_valid_r   <= in_fire || (a_valid_r && !a_to_b);
      b_valid_r   <= a_to_b || (b_valid_r && !b_done);
      out_valid_r <= b_done || (out_valid_r && !out_tready);
      regs_r      <= regs_nxt;
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + MEM_AW'(1);
        if (clr_addr_r == MEM_AW'(MEM_WORDS - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (cfg_wr_en) begin
        prog_len_r <= cfg_wr_data;
      end
      if (b_done) begin
        pc_r    <= ex.pc;
        cycle_r <= ex.cycle;
        io_r    <= ex.io;
      end
    end
  end

  a_no_exec_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !a_valid_r && !b_valid_r)
    else $error("instruction in flight during memory clear");

  a_both_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && b_valid_r && !b_done |=> b_valid_r && $stable(b_mode_r) && $stable(b_opd_r))
    else $error("execute stage lost its instruction");

  a_fault_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    b_done && ex.status != ST_OK |=> $stable(pc_r) && $stable(regs_r) && $stable(cycle_r))
    else $error("faulted step changed machine state");

  a_fault_no_store: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && ex.status != ST_OK |-> !ex.mem_we && !ex.wr_valid)
    else $error("faulted step stores or writes");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    b_done |=> out_valid_r && !b_valid_r)
    else $error("completed step did not reach the result register");

endmodule

[test/tb_register_machine_step_core.sv]
`timescale 1ns / 1ps

module tb_register_machine_step_core;
  import rms_pkg::*;

  localparam logic [4:0] OP_LAST_CODE = 5'd31;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic [WORD_W-1:0] pc;
    status_t           st;
    logic              wv;
    logic [WORD_W-1:0] wval;
    logic [WORD_W-1:0] cyc;
    logic [WORD_W-1:0] io;
  } step_out_t;

  typedef struct {
    bit                is_cfg;
    logic [PLEN_W-1:0] plen;
    logic [4:0]        code;
    logic [WORD_W-1:0] opd;
    bit                known;
    step_out_t         want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_wr_en = 1'b0;
  logic [PLEN_W-1:0] cfg_wr_data = '0;

  logic [WORD_W-1:0] mreg [NUM_REGS];
  logic [WORD_W-1:0] dmem [MEM_WORDS];
  logic [WORD_W-1:0] m_pc;
  logic [WORD_W-1:0] m_cyc;
  logic [WORD_W-1:0] m_io;
  logic [PLEN_W-1:0] m_plen;

  step_out_t pending_steps [$];
  plan_row_t plan [$];

  int errors = 0;
  int n_instrs = 0;
  int n_steps = 0;
  int n_writes = 0;
  int n_settings = 0;
  int st_seen [4] = '{0, 0, 0, 0};
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_done = 0;
  int hold_left = 0;

  register_machine_step_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("register_machine_step_core verification failed");
    $finish;
  end

  always @(negedge clk) begin
    if (hold_asked != hold_done) begin
      hold_done = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic cmp_field(input string what, input logic [WORD_W-1:0] want,
                           input logic [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    step_out_t seen;
    step_out_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      seen.pc   = out_tdata[63:0];
      seen.st   = status_t'(out_tdata[65:64]);
      seen.wv   = out_tdata[66];
      seen.wval = out_tdata[130:67];
      seen.cyc  = out_tdata[194:131];
      seen.io   = out_tdata[258:195];
      n_steps++;
      st_seen[seen.st]++;
      if (seen.wv) n_writes++;
      if (pending_steps.size() == 0) begin
        $display("%0t unexpected result beat: expected none, got pc %h status %0d",
                 $time, seen.pc, seen.st);
        errors++;
      end else begin
        want = pending_steps.pop_front();
        cmp_field("next_pc", want.pc, seen.pc);
        cmp_field("status", WORD_W'(want.st), WORD_W'(seen.st));
        cmp_field("write_valid", WORD_W'(want.wv), WORD_W'(seen.wv));
        cmp_field("write_value", want.wval, seen.wval);
        cmp_field("cycle_total", want.cyc, seen.cyc);
        cmp_field("io_total", want.io, seen.io);
      end
    end
  end

  function automatic logic [WORD_W-1:0] run_bound();
    return (m_plen < PROG_WORDS) ? WORD_W'(m_plen) : WORD_W'(PROG_WORDS);
  endfunction

  task automatic exec_instr(input logic [4:0] code, input logic [WORD_W-1:0] opd,
                            output step_out_t res);
    logic [REG_IDX_W-1:0] ri;
    logic [WORD_W-1:0]    addr;
    logic [WORD_W-1:0]    tmp;
    ri = opd[REG_IDX_W-1:0];
    res.st = ST_OK;
    res.wv = 1'b0;
    res.wval = '0;
    if (m_pc >= run_bound()) begin
      res.st = ST_PC_OOB;
    end else if (code == OP_HALT) begin
      res.st = ST_HALT;
    end else if (code >= OP_LOAD && code <= OP_RSTORE) begin
      addr = (code == OP_LOAD || code == OP_STORE) ? opd : mreg[ri];
      if (addr >= MEM_WORDS) begin
        res.st = ST_ADDR_OOB;
      end else begin
        if (code == OP_LOAD || code == OP_RLOAD) mreg[0] = dmem[addr[MEM_AW-1:0]];
        else dmem[addr[MEM_AW-1:0]] = mreg[0];
        m_cyc += COST_MEM;
        m_pc += 1;
      end
    end else begin
      case (code)
        OP_READ: begin
          mreg[0] = '0;
          m_io += COST_IO;
          m_pc += 1;
        end
        OP_WRITE: begin
          res.wv = 1'b1;
          res.wval = mreg[0];
          m_io += COST_IO;
          m_pc += 1;
        end
        OP_ADD: begin
          mreg[0] = mreg[0] + mreg[ri];
          m_cyc += COST_ALU;
          m_pc += 1;
        end
        OP_SUB: begin
          mreg[0] = (mreg[0] >= mreg[ri]) ? mreg[0] - mreg[ri] : '0;
          m_cyc += COST_ALU;
          m_pc += 1;
        end
        OP_SWP: begin
          tmp = mreg[ri];
          mreg[ri] = mreg[0];
          mreg[0] = tmp;
          m_cyc += COST_ALU;
          m_pc += 1;
        end
        OP_RST, OP_INC, OP_DEC, OP_SHL, OP_SHR: begin
          case (code)
            OP_RST: mreg[ri] = '0;
            OP_INC: mreg[ri] = mreg[ri] + 1;
            OP_DEC: if (mreg[ri] != 0) mreg[ri] = mreg[ri] - 1;
            OP_SHL: mreg[ri] = mreg[ri] << 1;
            default: mreg[ri] = mreg[ri] >> 1;
          endcase
          m_cyc += COST_ONE;
          m_pc += 1;
        end
        OP_JUMP: begin
          m_pc = opd;
          m_cyc += COST_ONE;
        end
        OP_JPOS: begin
          m_pc = (mreg[0] != 0) ? opd : m_pc + 1;
          m_cyc += COST_ONE;
        end
        OP_JZERO: begin
          m_pc = (mreg[0] == 0) ? opd : m_pc + 1;
          m_cyc += COST_ONE;
        end
        OP_CALL: begin
          mreg[0] = m_pc + 1;
          m_pc = opd;
          m_cyc += COST_ONE;
        end
        OP_RTRN: begin
          m_pc = mreg[0];
          m_cyc += COST_ONE;
        end
        default: ;
      endcase
    end
    res.pc = m_pc;
    res.cyc = m_cyc;
    res.io = m_io;
  endtask

  function automatic logic [WORD_W-1:0] jump_target(input logic [WORD_W-1:0] lim,
                                                    input bit may_leave);
    if (lim == 0) return '0;
    if (may_leave && lim < PROG_WORDS && $urandom_range(0, 49) == 0)
      return WORD_W'($urandom_range(lim, PROG_WORDS - 1));
    return WORD_W'($urandom_range(0, lim - 1));
  endfunction

  task automatic pick_instr(output logic [4:0] code, output logic [WORD_W-1:0] opd);
    logic [WORD_W-1:0] lim;
    int r;
    int k;
    bit hit;
    lim = run_bound();
    hit = 1'b0;
    r = $urandom_range(0, 99);
    opd = {$urandom, $urandom};
    if (r < 4) code = 5'($urandom_range(OP_HALT + 1, OP_LAST_CODE));
    else if (r < 6) code = OP_HALT;
    else if (r < 18) code = $urandom_range(0, 1) ? OP_ADD : OP_SHL;
    else code = 5'($urandom_range(OP_READ, OP_RTRN));
    case (code)
      OP_LOAD, OP_STORE:
        if ($urandom_range(0, 9) < 8)
          opd = $urandom_range(0, 1) ? WORD_W'($urandom_range(0, 15))
                                     : WORD_W'($urandom_range(0, MEM_WORDS - 1));
      OP_RLOAD, OP_RSTORE:
        if ($urandom_range(0, 9) < 8) begin
          k = $urandom_range(0, NUM_REGS - 1);
          for (int i = 0; i < NUM_REGS; i++)
            if (!hit && mreg[(k + i) % NUM_REGS] < MEM_WORDS) begin
              opd[REG_IDX_W-1:0] = REG_IDX_W'((k + i) % NUM_REGS);
              hit = 1'b1;
            end
        end
      OP_JUMP, OP_JPOS, OP_JZERO, OP_CALL:
        opd = jump_target(lim, 1'b1);
      OP_RTRN:
        if (mreg[0] >= lim) begin
          code = OP_CALL;
          opd = jump_target(lim, 1'b0);
        end
      default: ;
    endcase
    // steer back before running off the end of the program
    if (m_pc + 1 >= lim && $urandom_range(0, 19) != 0) begin
      code = OP_JUMP;
      opd = jump_target(lim, 1'b0);
    end
  endtask

  task automatic offer_instr(input logic [4:0] code, input logic [WORD_W-1:0] opd,
                             input bit known, input step_out_t want);
    step_out_t got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_W'({opd, code});
    do @(posedge clk); while (in_tready !== 1'b1);
    exec_instr(code, opd, got);
    pending_steps.insert(pending_steps.size(), known ? want : got);
    n_instrs++;
    @(negedge clk);
  endtask

  task automatic settle_and_set(input logic [PLEN_W-1:0] plen);
    in_tvalid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= plen;
    m_plen = plen;
    n_settings++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic plan_cfg(input logic [PLEN_W-1:0] plen);
    plan_row_t row;
    row.is_cfg = 1'b1;
    row.plen = plen;
    row.code = OP_HALT;
    row.opd = '0;
    row.known = 1'b0;
    plan.insert(plan.size(), row);
  endtask

  task automatic plan_op(input logic [4:0] code, input logic [WORD_W-1:0] opd);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.plen = '0;
    row.code = code;
    row.opd = opd;
    row.known = 1'b0;
    plan.insert(plan.size(), row);
  endtask

  task automatic plan_chk(input logic [4:0] code, input logic [WORD_W-1:0] opd,
                          input logic [WORD_W-1:0] pc, input status_t st, input logic wv,
                          input logic [WORD_W-1:0] wval, input logic [WORD_W-1:0] cyc,
                          input logic [WORD_W-1:0] io);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.plen = '0;
    row.code = code;
    row.opd = opd;
    row.known = 1'b1;
    row.want.pc = pc;
    row.want.st = st;
    row.want.wv = wv;
    row.want.wval = wval;
    row.want.cyc = cyc;
    row.want.io = io;
    plan.insert(plan.size(), row);
  endtask

  task automatic run_phase(input logic [PLEN_W-1:0] plen, input int count, input int idle_in,
                           input int stall_out, input bit hold);
    logic [4:0]        code;
    logic [WORD_W-1:0] opd;
    logic [PLEN_W-1:0] p;
    step_out_t         none;
    p = plen;
    if (m_pc < PROG_WORDS && m_pc >= ((p < PROG_WORDS) ? p : PROG_WORDS))
      p = PLEN_W'(m_pc + 1);
    settle_and_set(p);
    @(posedge clk);
    send_idle_pct = idle_in;
    stall_pct = stall_out;
    if (hold) hold_asked++;
    @(negedge clk);
    for (int i = 0; i < count; i++) begin
      pick_instr(code, opd);
      offer_instr(code, opd, 1'b0, none);
    end
    // rewind so the next setting starts inside the program
    if (m_pc < run_bound()) offer_instr(OP_JUMP, '0, 1'b0, none);
  endtask

  initial begin
    step_out_t none;
    for (int i = 0; i < NUM_REGS; i++) mreg[i] = '0;
    for (int i = 0; i < MEM_WORDS; i++) dmem[i] = '0;
    m_pc = '0;
    m_cyc = '0;
    m_io = '0;
    m_plen = '0;

    plan_cfg('0);
    plan_chk(OP_HALT, '0, 64'd0, ST_PC_OOB, 1'b0, '0, 64'd0, 64'd0);
    plan_cfg('1);
    plan_chk(OP_READ, '0, 64'd1, ST_OK, 1'b0, '0, 64'd0, 64'd100);
    plan_chk(OP_WRITE, '0, 64'd2, ST_OK, 1'b1, '0, 64'd0, 64'd200);
    plan_chk(OP_HALT, '0, 64'd2, ST_HALT, 1'b0, '0, 64'd0, 64'd200);
    plan_chk(OP_LOAD, 64'd1024, 64'd2, ST_ADDR_OOB, 1'b0, '0, 64'd0, 64'd200);
    plan_chk(OP_STORE, '1, 64'd2, ST_ADDR_OOB, 1'b0, '0, 64'd0, 64'd200);
    plan_chk(OP_DEC, '0, 64'd3, ST_OK, 1'b0, '0, 64'd1, 64'd200);
    plan_op(OP_SUB, 64'h8000_0000_0000_0007);
    plan_op(OP_INC, 64'hFFFF_FFFF_FFFF_FFF9);
    plan_op(OP_SWP, 64'd1);
    plan_op(OP_SHL, '0);
    plan_op(OP_ADD, '0);
    plan_op(OP_STORE, 64'd1023);
    plan_op(OP_RST, '0);
    plan_op(OP_LOAD, 64'd1023);
    plan_op(OP_RSTORE, 64'd2);
    plan_op(OP_RLOAD, 64'd2);
    plan_op(OP_JPOS, 64'd10);
    plan_op(OP_JZERO, 64'd5);
    plan_op(OP_CALL, 64'd20);
    plan_op(OP_SHR, '0);
    plan_op(OP_RTRN, '0);
    plan_op(OP_LAST_CODE, '1);
    plan_cfg(PLEN_W'(100));
    plan_op(OP_JUMP, 64'd100);
    plan_op(OP_INC, '0);
    plan_cfg(PLEN_W'(PROG_WORDS));

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) settle_and_set(plan[i].plen);
      else offer_instr(plan[i].code, plan[i].opd, plan[i].known, plan[i].want);
    end

    run_phase(PLEN_W'(PROG_WORDS), 120, 0, 0, 1'b1);
    run_phase(PLEN_W'(1), 15, 65, 0, 1'b0);
    run_phase('1, 110, 65, 0, 1'b0);
    run_phase(PLEN_W'($urandom_range(2, 300)), 100, 0, 65, 1'b0);
    run_phase(PLEN_W'($urandom_range(16, 8191)), 100, 36, 36, 1'b0);

    // leave the program for good, then probe the stuck counter
    offer_instr(OP_JUMP, '1, 1'b0, none);
    offer_instr(OP_HALT, '0, 1'b0, none);
    in_tvalid <= 1'b0;

    while (pending_steps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d instructions under %0d program lengths; %0d results checked, %0d writes.",
             n_instrs, n_settings, n_steps, n_writes);
    $display("Status mix: %0d executed, %0d halted, %0d pc out of bounds, %0d bad address.",
             st_seen[ST_OK], st_seen[ST_HALT], st_seen[ST_PC_OOB], st_seen[ST_ADDR_OOB]);
    if (errors == 0) begin
      $display("register_machine_step_core verification clean");
    end else begin
      $display("register_machine_step_core verification failed");
    end
    $finish;
  end

endmodule

[register_machine_step_core.f]
rtl/rms_pkg.sv
rtl/rms_exec.sv
rtl/register_machine_step_core.sv
test/tb_register_machine_step_core.sv
